// ===== hdl/ddcpid_pkg.sv =====
// Shared types and constants for the differential drive cascaded PID block.
package ddcpid_pkg;

   localparam int GAIN_W    = 16;
   localparam int NUM_REGS  = 8;
   localparam int CSR_IDX_W = 3;
   localparam int DRIVE_W   = 10;
   localparam int TARGET_W  = 10;

   localparam logic [CSR_IDX_W-1:0] REG_STEER_KP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEER_KI = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEER_KD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_KP  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_KI  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_KD  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_KP = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_KI = 3'd7;

   localparam logic [GAIN_W-1:0] GAIN_RESET [NUM_REGS] = '{
      16'd0, 16'd0, 16'd0, 16'd4352, 16'd256, 16'd205, 16'd3584, 16'd154
   };

   localparam int TARGET_MIN = 10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_DRAIN,
      ST_POST,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      LOOP_STEER,
      LOOP_LEFT,
      LOOP_RIGHT
   } loop_type;

   typedef enum logic [1:0] {
      TERM_P,
      TERM_I,
      TERM_D
   } term_type;

endpackage

// ===== hdl/differential_drive_cascaded_pid.sv =====
// Top level: steering PID cascaded into two wheel PIDs on one shared multiplier.
//
// One control tick is one request transfer. An update tick runs the steering
// loop, then the left and the right wheel loop, each as a preparation state
// (error, saturating integrator, difference), three multiplies on the single
// 17x32 signed multiplier with accumulation overlapped, a drain state and a
// scaling/clamp state. A held tick skips the loops. Either kind then goes to
// the output state, which loads the response register once it is free and
// returns to idle. Requests are stalled while a tick is in progress; a
// finished response waits in its own register so the next request can be
// taken while it is still stalled downstream.
module differential_drive_cascaded_pid #(
   parameter int TARGET_MAX = 300,
   parameter int DRIVE_MAX  = 1000
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [10:0]                     req_line_error,
   input  logic        [9:0]                      req_base_speed,
   input  logic signed [15:0]                     req_left_speed,
   input  logic signed [15:0]                     req_right_speed,
   input  logic                                   req_hold,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [ddcpid_pkg::DRIVE_W-1:0]         rsp_left_drive,
   output logic [ddcpid_pkg::DRIVE_W-1:0]         rsp_right_drive,
   output logic                                   rsp_updated,
   input  logic                                   csr_wen,
   input  logic [ddcpid_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ddcpid_pkg::GAIN_W-1:0]          csr_wdata
);

   localparam logic [ddcpid_pkg::DRIVE_W-1:0] DRIVE_MAX_LO = ddcpid_pkg::DRIVE_W'(DRIVE_MAX);

   ddcpid_pkg::state_type state_ff, state_in;
   ddcpid_pkg::loop_type  loop_ff, loop_in;
   ddcpid_pkg::term_type  term_ff, term_in;

   logic [ddcpid_pkg::GAIN_W-1:0] gain_ff [ddcpid_pkg::NUM_REGS];
   logic [ddcpid_pkg::GAIN_W-1:0] gain_in [ddcpid_pkg::NUM_REGS];

   logic signed [31:0] steer_int_ff, steer_int_in;
   logic signed [31:0] left_int_ff, left_int_in;
   logic signed [31:0] right_int_ff, right_int_in;
   logic signed [10:0] steer_prev_ff, steer_prev_in;
   logic signed [17:0] left_prev_ff, left_prev_in;
   logic signed [17:0] right_prev_ff, right_prev_in;
   logic [ddcpid_pkg::DRIVE_W-1:0] last_left_ff, last_left_in;
   logic [ddcpid_pkg::DRIVE_W-1:0] last_right_ff, last_right_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [10:0] line_error_ff, line_error_in;
   logic [9:0]         base_ff, base_in;
   logic signed [15:0] lspeed_ff, lspeed_in;
   logic signed [15:0] rspeed_ff, rspeed_in;
   logic               upd_ff, upd_in;
   logic signed [17:0] err_ff, err_in;
   logic signed [18:0] diff_ff, diff_in;
   logic signed [48:0] prod_ff, prod_in;
   logic signed [51:0] acc_ff, acc_in;
   logic [ddcpid_pkg::TARGET_W-1:0] lt_ff, lt_in;
   logic [ddcpid_pkg::TARGET_W-1:0] rt_ff, rt_in;
   logic [ddcpid_pkg::DRIVE_W-1:0] rsp_left_ff, rsp_left_in;
   logic [ddcpid_pkg::DRIVE_W-1:0] rsp_right_ff, rsp_right_in;
   logic rsp_upd_ff, rsp_upd_in;

   logic signed [17:0] e_new;
   logic signed [31:0] int_cur;
   logic signed [17:0] prev_cur;
   logic signed [32:0] int_sum;
   logic signed [31:0] int_sat;
   logic signed [18:0] diff_new;
   logic [ddcpid_pkg::GAIN_W-1:0] gain_sel;
   logic signed [31:0] op_sel;
   logic signed [48:0] mul_res;
   logic signed [51:0] acc_sum;
   logic signed [51:0] acc_rnd;
   logic signed [43:0] q;
   logic signed [45:0] sum_l, sum_r;
   logic out_free;

   function automatic logic [ddcpid_pkg::TARGET_W-1:0] clamp_target(logic signed [45:0] v);
      logic [ddcpid_pkg::TARGET_W-1:0] r;
      if (v < 46'(ddcpid_pkg::TARGET_MIN)) begin
         r = ddcpid_pkg::TARGET_W'(ddcpid_pkg::TARGET_MIN);
      end else if (v > 46'(TARGET_MAX)) begin
         r = ddcpid_pkg::TARGET_W'(TARGET_MAX);
      end else begin
         r = v[ddcpid_pkg::TARGET_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [ddcpid_pkg::DRIVE_W-1:0] clamp_drive(logic signed [43:0] v);
      logic [ddcpid_pkg::DRIVE_W-1:0] r;
      if (v[43]) begin
         r = '0;
      end else if (v > 44'(DRIVE_MAX)) begin
         r = DRIVE_MAX_LO;
      end else begin
         r = v[ddcpid_pkg::DRIVE_W-1:0];
      end
      return r;
   endfunction

   assign req_stall       = (state_ff != ddcpid_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_drive  = rsp_left_ff;
   assign rsp_right_drive = rsp_right_ff;
   assign rsp_updated     = rsp_upd_ff;
   assign out_free        = !rsp_valid_ff || !rsp_stall;

   // datapath: error, integrator, multiplier operands, scaling
   always_comb begin
      unique case (loop_ff)
         ddcpid_pkg::LOOP_STEER: begin
            e_new    = {{7{line_error_ff[10]}}, line_error_ff};
            int_cur  = steer_int_ff;
            prev_cur = {{7{steer_prev_ff[10]}}, steer_prev_ff};
         end
         ddcpid_pkg::LOOP_LEFT: begin
            e_new    = $signed({8'b0, lt_ff}) - $signed({{2{lspeed_ff[15]}}, lspeed_ff});
            int_cur  = left_int_ff;
            prev_cur = left_prev_ff;
         end
         default: begin
            e_new    = $signed({8'b0, rt_ff}) - $signed({{2{rspeed_ff[15]}}, rspeed_ff});
            int_cur  = right_int_ff;
            prev_cur = right_prev_ff;
         end
      endcase

      int_sum = $signed({int_cur[31], int_cur}) + $signed({{15{e_new[17]}}, e_new});
      if (int_sum[32] != int_sum[31]) begin
         int_sat = int_sum[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
      end else begin
         int_sat = int_sum[31:0];
      end
      diff_new = $signed({e_new[17], e_new}) - $signed({prev_cur[17], prev_cur});

      gain_sel = '0;
      unique case (loop_ff)
         ddcpid_pkg::LOOP_STEER: begin
            case (term_ff)
               ddcpid_pkg::TERM_P: gain_sel = gain_ff[ddcpid_pkg::REG_STEER_KP];
               ddcpid_pkg::TERM_I: gain_sel = gain_ff[ddcpid_pkg::REG_STEER_KI];
               default:            gain_sel = gain_ff[ddcpid_pkg::REG_STEER_KD];
            endcase
         end
         ddcpid_pkg::LOOP_LEFT: begin
            case (term_ff)
               ddcpid_pkg::TERM_P: gain_sel = gain_ff[ddcpid_pkg::REG_LEFT_KP];
               ddcpid_pkg::TERM_I: gain_sel = gain_ff[ddcpid_pkg::REG_LEFT_KI];
               default:            gain_sel = gain_ff[ddcpid_pkg::REG_LEFT_KD];
            endcase
         end
         default: begin
            // right wheel has no D gain
            case (term_ff)
               ddcpid_pkg::TERM_P: gain_sel = gain_ff[ddcpid_pkg::REG_RIGHT_KP];
               ddcpid_pkg::TERM_I: gain_sel = gain_ff[ddcpid_pkg::REG_RIGHT_KI];
               default:            gain_sel = '0;
            endcase
         end
      endcase

      case (term_ff)
         ddcpid_pkg::TERM_P: op_sel = {{14{err_ff[17]}}, err_ff};
         ddcpid_pkg::TERM_I: op_sel = int_cur;
         default:            op_sel = {{13{diff_ff[18]}}, diff_ff};
      endcase

      mul_res = $signed({1'b0, gain_sel}) * op_sel;
      acc_sum = acc_ff + $signed({{3{prod_ff[48]}}, prod_ff});

      // divide by 256, truncating toward zero
      acc_rnd = acc_ff + (acc_ff[51] ? 52'sd255 : 52'sd0);
      q       = acc_rnd[51:8];
      sum_l   = $signed({36'b0, base_ff}) + $signed({{2{q[43]}}, q});
      sum_r   = $signed({36'b0, base_ff}) - $signed({{2{q[43]}}, q});
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      loop_in       = loop_ff;
      term_in       = term_ff;
      gain_in       = gain_ff;
      steer_int_in  = steer_int_ff;
      left_int_in   = left_int_ff;
      right_int_in  = right_int_ff;
      steer_prev_in = steer_prev_ff;
      left_prev_in  = left_prev_ff;
      right_prev_in = right_prev_ff;
      last_left_in  = last_left_ff;
      last_right_in = last_right_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      line_error_in = line_error_ff;
      base_in       = base_ff;
      lspeed_in     = lspeed_ff;
      rspeed_in     = rspeed_ff;
      upd_in        = upd_ff;
      err_in        = err_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      lt_in         = lt_ff;
      rt_in         = rt_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_upd_in    = rsp_upd_ff;

      if (csr_wen) begin
         gain_in[csr_index] = csr_wdata;
      end

      unique case (state_ff)
         ddcpid_pkg::ST_IDLE: begin
            if (req_valid) begin
               line_error_in = req_line_error;
               base_in       = req_base_speed;
               lspeed_in     = req_left_speed;
               rspeed_in     = req_right_speed;
               upd_in        = !req_hold;
               loop_in       = ddcpid_pkg::LOOP_STEER;
               state_in      = req_hold ? ddcpid_pkg::ST_OUT : ddcpid_pkg::ST_PREP;
            end
         end
         ddcpid_pkg::ST_PREP: begin
            err_in  = e_new;
            diff_in = diff_new;
            acc_in  = '0;
            term_in = ddcpid_pkg::TERM_P;
            unique case (loop_ff)
               ddcpid_pkg::LOOP_STEER: begin
                  steer_int_in  = int_sat;
                  steer_prev_in = e_new[10:0];
               end
               ddcpid_pkg::LOOP_LEFT: begin
                  left_int_in  = int_sat;
                  left_prev_in = e_new;
               end
               default: begin
                  right_int_in  = int_sat;
                  right_prev_in = e_new;
               end
            endcase
            state_in = ddcpid_pkg::ST_MUL;
         end
         ddcpid_pkg::ST_MUL: begin
            prod_in = mul_res;
            if (term_ff != ddcpid_pkg::TERM_P) begin
               acc_in = acc_sum;
            end
            case (term_ff)
               ddcpid_pkg::TERM_P: term_in = ddcpid_pkg::TERM_I;
               ddcpid_pkg::TERM_I: term_in = ddcpid_pkg::TERM_D;
               default:            state_in = ddcpid_pkg::ST_DRAIN;
            endcase
         end
         ddcpid_pkg::ST_DRAIN: begin
            acc_in   = acc_sum;
            state_in = ddcpid_pkg::ST_POST;
         end
         ddcpid_pkg::ST_POST: begin
            unique case (loop_ff)
               ddcpid_pkg::LOOP_STEER: begin
                  lt_in    = clamp_target(sum_l);
                  rt_in    = clamp_target(sum_r);
                  loop_in  = ddcpid_pkg::LOOP_LEFT;
                  state_in = ddcpid_pkg::ST_PREP;
               end
               ddcpid_pkg::LOOP_LEFT: begin
                  last_left_in = clamp_drive(q);
                  loop_in      = ddcpid_pkg::LOOP_RIGHT;
                  state_in     = ddcpid_pkg::ST_PREP;
               end
               default: begin
                  last_right_in = clamp_drive(q);
                  state_in      = ddcpid_pkg::ST_OUT;
               end
            endcase
         end
         ddcpid_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = last_left_ff;
               rsp_right_in = last_right_ff;
               rsp_upd_in   = upd_ff;
               state_in     = ddcpid_pkg::ST_IDLE;
            end
         end
         default: state_in = ddcpid_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ddcpid_pkg::ST_IDLE;
         loop_ff       <= ddcpid_pkg::LOOP_STEER;
         term_ff       <= ddcpid_pkg::TERM_P;
         gain_ff       <= ddcpid_pkg::GAIN_RESET;
         steer_int_ff  <= '0;
         left_int_ff   <= '0;
         right_int_ff  <= '0;
         steer_prev_ff <= '0;
         left_prev_ff  <= '0;
         right_prev_ff <= '0;
         last_left_ff  <= '0;
         last_right_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         loop_ff       <= loop_in;
         term_ff       <= term_in;
         gain_ff       <= gain_in;
         steer_int_ff  <= steer_int_in;
         left_int_ff   <= left_int_in;
         right_int_ff  <= right_int_in;
         steer_prev_ff <= steer_prev_in;
         left_prev_ff  <= left_prev_in;
         right_prev_ff <= right_prev_in;
         last_left_ff  <= last_left_in;
         last_right_ff <= last_right_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      line_error_ff <= line_error_in;
      base_ff       <= base_in;
      lspeed_ff     <= lspeed_in;
      rspeed_ff     <= rspeed_in;
      upd_ff        <= upd_in;
      err_ff        <= err_in;
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      lt_ff         <= lt_in;
      rt_ff         <= rt_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_right_ff  <= rsp_right_in;
      rsp_upd_ff    <= rsp_upd_in;
   end

endmodule

// ===== hdl/ddcpid_checker.sv =====
// Port-level checker for the differential drive cascaded PID block, with its bind.
module ddcpid_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_hold,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [ddcpid_pkg::DRIVE_W-1:0]    rsp_left_drive,
   input logic [ddcpid_pkg::DRIVE_W-1:0]    rsp_right_drive,
   input logic                              rsp_updated
);

   logic [ddcpid_pkg::DRIVE_W-1:0] prev_left_ff;
   logic [ddcpid_pkg::DRIVE_W-1:0] prev_right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         prev_left_ff  <= rsp_left_drive;
         prev_right_ff <= rsp_right_drive;
      end
   end

   // stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_left_drive) && $stable(rsp_right_drive)
          && $stable(rsp_updated)))
      else $error("stalled response changed");

   // one tick at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while a tick is in progress");

   // a held tick with a free response register is answered without an update
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_hold && !rsp_valid) |=> ##1
         (rsp_valid && !rsp_updated))
      else $error("held tick not answered in time");

   // a held response repeats the previous drives
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_updated) |->
         (rsp_left_drive == prev_left_ff && rsp_right_drive == prev_right_ff))
      else $error("held response does not repeat last drives");

endmodule

bind differential_drive_cascaded_pid ddcpid_checker u_ddcpid_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_hold        (req_hold),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_left_drive  (rsp_left_drive),
   .rsp_right_drive (rsp_right_drive),
   .rsp_updated     (rsp_updated)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the differential drive cascaded PID block.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     TARGET_MAX  = 300;
   localparam int     DRIVE_MAX   = 1000;
   localparam int     STALL_LIMIT = 2000;
   localparam int     DRAIN_WAIT  = 40;
   localparam longint ACC_MAX     = 64'sd2147483647;
   localparam longint ACC_MIN     = -64'sd2147483648;

   typedef struct packed {
      logic [ddcpid_pkg::DRIVE_W-1:0] left_drive;
      logic [ddcpid_pkg::DRIVE_W-1:0] right_drive;
      logic                           updated;
   } drive_out_type;

   typedef logic [ddcpid_pkg::GAIN_W-1:0] gain_set_type [ddcpid_pkg::NUM_REGS];

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic signed [10:0]                  req_line_error = '0;
   logic        [9:0]                   req_base_speed = '0;
   logic signed [15:0]                  req_left_speed = '0;
   logic signed [15:0]                  req_right_speed = '0;
   logic                                req_hold = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b1;
   logic [ddcpid_pkg::DRIVE_W-1:0]      rsp_left_drive;
   logic [ddcpid_pkg::DRIVE_W-1:0]      rsp_right_drive;
   logic                                rsp_updated;
   logic                                csr_wen = 1'b0;
   logic [ddcpid_pkg::CSR_IDX_W-1:0]    csr_index = ddcpid_pkg::REG_STEER_KP;
   logic [ddcpid_pkg::GAIN_W-1:0]       csr_wdata = '0;

   // controller image
   logic [ddcpid_pkg::GAIN_W-1:0]       gain_q [ddcpid_pkg::NUM_REGS];
   int                                  steer_integ, left_integ, right_integ;
   int                                  steer_err_last, left_err_last, right_err_last;
   logic [ddcpid_pkg::DRIVE_W-1:0]      last_left, last_right;

   drive_out_type                       drives_due [$];
   int                                  mismatches = 0;
   int                                  idle_cycles = 0;
   bit                                  req_calm = 1'b0;
   bit                                  rsp_calm = 1'b0;

   differential_drive_cascaded_pid #(
      .TARGET_MAX (TARGET_MAX),
      .DRIVE_MAX  (DRIVE_MAX)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_line_error  (req_line_error),
      .req_base_speed  (req_base_speed),
      .req_left_speed  (req_left_speed),
      .req_right_speed (req_right_speed),
      .req_hold        (req_hold),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_drive  (rsp_left_drive),
      .rsp_right_drive (rsp_right_drive),
      .rsp_updated     (rsp_updated),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int sat_acc(int acc, longint delta);
      longint s;
      s = longint'(acc) + delta;
      if (s > ACC_MAX) s = ACC_MAX;
      if (s < ACC_MIN) s = ACC_MIN;
      return int'(s);
   endfunction

   // Q8.8 PID sum, truncated toward zero
   function automatic longint pid_q8(logic [ddcpid_pkg::GAIN_W-1:0] kp,
                                     logic [ddcpid_pkg::GAIN_W-1:0] ki,
                                     logic [ddcpid_pkg::GAIN_W-1:0] kd,
                                     longint err, longint integ, longint diff);
      longint sum;
      sum = longint'(kp) * err + longint'(ki) * integ + longint'(kd) * diff;
      return sum / 256;
   endfunction

   function automatic longint clamp_to(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic drive_out_type step_drives(logic signed [10:0] line_err,
                                                 logic [9:0] base,
                                                 logic signed [15:0] lspd,
                                                 logic signed [15:0] rspd, logic hold);
      drive_out_type r;
      longint        err, steer, lt, rt, le, re, ld, rd;
      if (hold) begin
         r.left_drive  = last_left;
         r.right_drive = last_right;
         r.updated     = 1'b0;
         return r;
      end
      err = line_err;
      steer_integ = sat_acc(steer_integ, err);
      steer = pid_q8(gain_q[ddcpid_pkg::REG_STEER_KP], gain_q[ddcpid_pkg::REG_STEER_KI],
                     gain_q[ddcpid_pkg::REG_STEER_KD],
                     err, steer_integ, err - steer_err_last);
      steer_err_last = int'(err);
      lt = clamp_to(longint'(base) + steer, ddcpid_pkg::TARGET_MIN, TARGET_MAX);
      rt = clamp_to(longint'(base) - steer, ddcpid_pkg::TARGET_MIN, TARGET_MAX);

      le = lt - longint'(lspd);
      left_integ = sat_acc(left_integ, le);
      ld = pid_q8(gain_q[ddcpid_pkg::REG_LEFT_KP], gain_q[ddcpid_pkg::REG_LEFT_KI],
                  gain_q[ddcpid_pkg::REG_LEFT_KD],
                  le, left_integ, le - left_err_last);
      left_err_last = int'(le);

      // right wheel has no derivative gain
      re = rt - longint'(rspd);
      right_integ = sat_acc(right_integ, re);
      rd = pid_q8(gain_q[ddcpid_pkg::REG_RIGHT_KP], gain_q[ddcpid_pkg::REG_RIGHT_KI], '0,
                  re, right_integ, re - right_err_last);
      right_err_last = int'(re);

      ld = clamp_to(ld, 0, DRIVE_MAX);
      rd = clamp_to(rd, 0, DRIVE_MAX);
      last_left  = ld[ddcpid_pkg::DRIVE_W-1:0];
      last_right = rd[ddcpid_pkg::DRIVE_W-1:0];
      r.left_drive  = last_left;
      r.right_drive = last_right;
      r.updated     = 1'b1;
      return r;
   endfunction

   function automatic void report_mismatch(string what, drive_out_type want,
                                           drive_out_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: expected left %0d right %0d upd %0b, got left %0d right %0d upd %0b",
                  $realtime, what, want.left_drive, want.right_drive, want.updated,
                  got.left_drive, got.right_drive, got.updated);
   endfunction

   task automatic send_tick(logic signed [10:0] line_err, logic [9:0] base,
                            logic signed [15:0] lspd, logic signed [15:0] rspd, logic hold);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_line_error  <= line_err;
      req_base_speed  <= base;
      req_left_speed  <= lspd;
      req_right_speed <= rspd;
      req_hold        <= hold;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      drives_due.push_back(step_drives(line_err, base, lspd, rspd, hold));
   endtask

   task automatic random_tick();
      logic signed [10:0] err;
      logic [9:0]         base;
      logic signed [15:0] lspd, rspd;
      case ($urandom_range(0, 7))
         0:       err = 11'($urandom);
         1:       err = ($urandom_range(0, 1) != 0) ? 11'sh3FF : 11'sh400;
         default: err = 11'($urandom_range(0, 80) - 40);
      endcase
      base = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 320));
      lspd = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400) - 50);
      rspd = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400) - 50);
      send_tick(err, base, lspd, rspd, $urandom_range(0, 5) == 0);
   endtask

   // gains may only change with the block idle
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (drives_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_gain(logic [ddcpid_pkg::CSR_IDX_W-1:0] idx,
                             logic [ddcpid_pkg::GAIN_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      gain_q[idx] = value;
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_gains(gain_set_type vals);
      for (int i = 0; i < ddcpid_pkg::NUM_REGS; i++)
         write_gain(ddcpid_pkg::CSR_IDX_W'(i), vals[i]);
   endtask

   // response side back-pressure
   always begin : rsp_pacing
      int gap;
      gap = rsp_calm ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
         rsp_stall <= 1'b1;
         @(posedge clock);
      end
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (!(rsp_valid && !rsp_stall)) @(posedge clock);
   end

   always @(posedge clock) begin : check_drives
      drive_out_type got;
      drive_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{left_drive: rsp_left_drive, right_drive: rsp_right_drive,
                 updated: rsp_updated};
         if (drives_due.size() == 0) begin
            report_mismatch("transfer with nothing expected", got, got);
         end else begin
            want = drives_due.pop_front();
            if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
                got.updated !== want.updated)
               report_mismatch("drive mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wen) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("differential_drive_cascaded_pid verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_hold_from_reset();
      send_tick(11'sh3FF, 10'd1023, 16'sh7FFF, -16'sd32768, 1'b1);
      send_tick('0, '0, '0, '0, 1'b1);
   endtask

   task automatic test_default_gains();
      send_tick('0, '0, '0, '0, 1'b0);
      send_tick(11'sh3FF, 10'd1023, -16'sd32768, -16'sd32768, 1'b0);
      send_tick(11'sh400, 10'd0, 16'sh7FFF, 16'sh7FFF, 1'b0);
      send_tick('0, 10'd150, 16'sd150, 16'sd150, 1'b1);
      send_tick('0, 10'd150, 16'sd140, 16'sd160, 1'b0);
      send_tick(11'sd5, 10'd200, 16'sd190, -16'sd200, 1'b0);
      settle();
   endtask

   task automatic test_steering_extremes();
      write_gain(ddcpid_pkg::REG_STEER_KP, 16'hFFFF);
      write_gain(ddcpid_pkg::REG_STEER_KI, 16'hFFFF);
      write_gain(ddcpid_pkg::REG_STEER_KD, 16'hFFFF);
      send_tick(11'sh3FF, 10'd512, 16'sd250, 16'sd20, 1'b0);
      send_tick(11'sh400, 10'd512, 16'sd20, 16'sd250, 1'b0);
      send_tick('0, 10'd1023, 16'sd300, 16'sd300, 1'b0);
      send_tick(11'sh3FF, 10'd0, '0, '0, 1'b1);
      send_tick(11'sh3FF, 10'd0, '0, '0, 1'b0);
      settle();
      write_gain(ddcpid_pkg::REG_STEER_KP, 16'd256);
      write_gain(ddcpid_pkg::REG_STEER_KI, 16'd0);
      write_gain(ddcpid_pkg::REG_STEER_KD, 16'd128);
      send_tick(11'sd40, 10'd150, 16'sd140, 16'sd160, 1'b0);
      send_tick(-11'sd40, 10'd150, 16'sd170, 16'sd120, 1'b0);
      send_tick(-11'sd3, 10'd12, 16'sd9, 16'sd11, 1'b0);
      settle();
   endtask

   task automatic test_wheel_gain_extremes();
      gain_set_type vals;
      vals = '{default: '0};
      load_gains(vals);
      send_tick(11'sd17, 10'd200, -16'sd500, -16'sd500, 1'b0);
      send_tick(11'sd17, 10'd200, -16'sd500, -16'sd500, 1'b1);
      settle();
      vals = '{default: 16'hFFFF};
      load_gains(vals);
      send_tick('0, 10'd100, 16'sd99, 16'sd101, 1'b0);
      send_tick('0, 10'd100, 16'sd120, 16'sd80, 1'b0);
      settle();
   endtask

   task automatic test_random_ticks();
      gain_set_type vals;
      for (int phase = 0; phase < 7; phase++) begin
         for (int i = 0; i < ddcpid_pkg::NUM_REGS; i++) begin
            case ($urandom_range(0, 5))
               0:       vals[i] = '0;
               1:       vals[i] = 16'hFFFF;
               2, 3:    vals[i] = 16'($urandom_range(0, 1023));
               4:       vals[i] = 16'($urandom_range(0, 8191));
               default: vals[i] = 16'($urandom);
            endcase
         end
         if (phase == 0) vals = ddcpid_pkg::GAIN_RESET;
         if (phase == 1) vals = '{default: 16'hFFFF};
         load_gains(vals);
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(0, 15) == 0) req_calm = !req_calm;
            if ($urandom_range(0, 15) == 0) rsp_calm = !rsp_calm;
            random_tick();
         end
         settle();
      end
      req_calm = 1'b0;
      rsp_calm = 1'b0;
   endtask

   // wind both wheel integrators up hard, then pull the errors the other way
   task automatic test_integrator_windup();
      gain_set_type vals;
      vals = '{default: '0};
      vals[ddcpid_pkg::REG_LEFT_KI]  = 16'd1;
      vals[ddcpid_pkg::REG_RIGHT_KI] = 16'd1;
      load_gains(vals);
      req_calm = 1'b1;
      rsp_calm = 1'b1;
      repeat (30) send_tick('0, 10'd1023, -16'sd32768, -16'sd32768, 1'b0);
      settle();
      vals[ddcpid_pkg::REG_LEFT_KP]  = 16'hFFFF;
      vals[ddcpid_pkg::REG_LEFT_KD]  = 16'd10;
      vals[ddcpid_pkg::REG_RIGHT_KP] = 16'hFFFF;
      load_gains(vals);
      repeat (4) send_tick('0, 10'd0, 16'sh7FFF, 16'sh7FFF, 1'b0);
      req_calm = 1'b0;
      rsp_calm = 1'b0;
      repeat (20) random_tick();
      settle();
   endtask

   initial begin
      gain_q = ddcpid_pkg::GAIN_RESET;
      steer_integ = 0;
      left_integ = 0;
      right_integ = 0;
      steer_err_last = 0;
      left_err_last = 0;
      right_err_last = 0;
      last_left = '0;
      last_right = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_hold_from_reset();
      test_default_gains();
      test_steering_extremes();
      test_wheel_gain_extremes();
      test_random_ticks();
      test_integrator_windup();

      settle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && drives_due.size() == 0) begin
         $display("differential_drive_cascaded_pid verification clean");
      end else begin
         $display("differential_drive_cascaded_pid verification failed");
      end
      $finish;
   end

endmodule
